// ===== hdl/ovl_pkg.sv =====
// ---------------------------------------------------------------------------
// ovl_pkg: shared types and constants for the ordered value list.
// Holds the command and status codes, the controller states and the
// command/status structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
package ovl_pkg;

   // Default number of list slots.
   localparam int DEPTH_DEF = 16;

   // Fixed field widths.
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;          // capture a new item and its match vector
      logic emit_single;   // finish a one-result command
      logic emit_read;     // emit the head value and rotate the list
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     empty;
      logic     last_read;
   } stat_type;

endpackage

// ===== hdl/ordered_value_list.sv =====
// ---------------------------------------------------------------------------
// ordered_value_list: bounded ordered list of signed 32-bit values.
// Insert appends at the tail, delete removes the first match and compacts,
// search reports the 1-based position of the first match, and read-out
// streams every stored value from head to tail.
// ---------------------------------------------------------------------------
// For insert, delete and search, the item is accepted and every cell
// compares against it in the same cycle, the registered match vector is
// resolved by a priority encoder in the next, the result is written once the
// result register is free, and the next item is accepted in the cycle after
// that. Read-out passes through the accept and execute states, then streams
// the stored values while the result side takes them; no new item is accepted
// until the run ends. The list rotates through its head cell during the run
// and ends in its original order. The result register lets a new item in
// while the last result still waits. No clearing pass is needed after reset.
module ordered_value_list #(
   parameter int DEPTH = ovl_pkg::DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ovl_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [ovl_pkg::VAL_W-1:0] req_item_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ovl_pkg::STAT_W-1:0]       rsp_status,
   output logic [ovl_pkg::POS_W-1:0]        rsp_position,
   output logic signed [ovl_pkg::VAL_W-1:0] rsp_value_out,
   output logic                             rsp_last_of_run
);
   import ovl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   ovl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // List cells and result register.
   ovl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_item_value  (req_item_value),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_value_out   (rsp_value_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== hdl/ovl_datapath.sv =====
// ---------------------------------------------------------------------------
// ovl_datapath: list cells, comparator bank and result register.
// Every cell compares itself against the incoming value; the match vector is
// registered and resolved by a priority encoder on the next cycle. Delete
// closes the gap by shifting cells toward the head, and read-out rotates the
// list so that the head cell is always the next value to emit.
// ---------------------------------------------------------------------------
module ovl_datapath #(
   parameter int DEPTH = ovl_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ovl_pkg::cmd_type                    cmd,
   output ovl_pkg::stat_type                   stat,
   input  logic [ovl_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [ovl_pkg::VAL_W-1:0]    req_item_value,
   output logic [ovl_pkg::STAT_W-1:0]          rsp_status,
   output logic [ovl_pkg::POS_W-1:0]           rsp_position,
   output logic signed [ovl_pkg::VAL_W-1:0]    rsp_value_out,
   output logic                                rsp_last_of_run
);
   import ovl_pkg::*;

   localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   // List storage and item registers.
   logic signed [VAL_W-1:0] cell_ff [DEPTH];
   logic signed [VAL_W-1:0] cell_in [DEPTH];
   logic signed [VAL_W-1:0] cell_up [DEPTH];
   logic [CNTW-1:0]         count_ff, count_in;
   func_type                func_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic [DEPTH-1:0]        match_ff, match_in;
   logic [IDXW-1:0]         rd_idx_ff;

   // Result register.
   status_type              status_ff, status_in;
   logic [POS_W-1:0]        position_ff, position_in;
   logic signed [VAL_W-1:0] value_out_ff, value_out_in;
   logic                    last_ff, last_in;

   // Decoded conditions.
   logic                    empty, full, found;
   logic [IDXW-1:0]         hit_idx;
   logic [CNTW-1:0]         hit_pos, rd_pos, tail_idx;
   logic [CNTW+POS_W-1:0]   hit_pos_ext, rd_pos_ext;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNTW'(DEPTH));
   assign tail_idx = count_ff - 1'b1;
   assign rd_pos   = CNTW'(rd_idx_ff) + 1'b1;
   assign hit_pos  = CNTW'(hit_idx) + 1'b1;

   // Positions keep their low bits when the list is deeper than the field.
   assign rd_pos_ext  = {{POS_W{1'b0}}, rd_pos};
   assign hit_pos_ext = {{POS_W{1'b0}}, hit_pos};

   assign stat.func      = func_ff;
   assign stat.empty     = empty;
   assign stat.last_read = (rd_pos == count_ff);

   // Comparator bank: one equality compare per occupied cell.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (cell_ff[i] == req_item_value) && (CNTW'(i) < count_ff);
      end
   end

   // First match nearest the head.
   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            found   = 1'b1;
            hit_idx = IDXW'(i);
         end
      end
   end

   // Each cell's upper neighbor, used by delete and read-out shifts.
   always_comb begin
      for (int i = 0; i < DEPTH - 1; i++) begin
         cell_up[i] = cell_ff[i + 1];
      end
      cell_up[DEPTH-1] = cell_ff[DEPTH-1];
   end

   // Next cell contents and fill count.
   always_comb begin
      cell_in  = cell_ff;
      count_in = count_ff;
      if (cmd.emit_single) begin
         unique case (func_ff)
            FUNC_INSERT: begin
               if (!full) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CNTW'(i) == count_ff) cell_in[i] = value_ff;
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_DELETE: begin
               if (!empty && found) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (IDXW'(i) >= hit_idx) cell_in[i] = cell_up[i];
                  end
                  count_in = count_ff - 1'b1;
               end
            end
            FUNC_SEARCH, FUNC_READ: begin
            end
         endcase
      end else if (cmd.emit_read) begin
         // Rotate: the head value wraps around to the tail slot.
         for (int i = 0; i < DEPTH; i++) begin
            cell_in[i] = (CNTW'(i) == tail_idx) ? cell_ff[0] : cell_up[i];
         end
      end
   end

   // Next result.
   always_comb begin
      status_in    = status_ff;
      position_in  = position_ff;
      value_out_in = value_out_ff;
      last_in      = last_ff;
      if (cmd.emit_single) begin
         position_in  = '0;
         value_out_in = '0;
         last_in      = 1'b1;
         unique case (func_ff)
            FUNC_INSERT: status_in = full ? ST_FULL : ST_OK;
            FUNC_DELETE: begin
               priority if (empty) status_in = ST_EMPTY;
               else if (!found)    status_in = ST_NOTFOUND;
               else                status_in = ST_OK;
            end
            FUNC_SEARCH: begin
               priority if (empty) status_in = ST_EMPTY;
               else if (!found)    status_in = ST_NOTFOUND;
               else begin
                  status_in   = ST_OK;
                  position_in = hit_pos_ext[POS_W-1:0];
               end
            end
            FUNC_READ: status_in = ST_EMPTY;
         endcase
      end else if (cmd.emit_read) begin
         status_in    = ST_OK;
         position_in  = rd_pos_ext[POS_W-1:0];
         value_out_in = cell_ff[0];
         last_in      = stat.last_read;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cell_ff      <= cell_in;
      status_ff    <= status_in;
      position_ff  <= position_in;
      value_out_ff <= value_out_in;
      last_ff      <= last_in;
      if (cmd.load) begin
         func_ff   <= func_type'(req_func);
         value_ff  <= req_item_value;
         match_ff  <= match_in;
         rd_idx_ff <= '0;
      end else if (cmd.emit_read) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_position    = position_ff;
   assign rsp_value_out   = value_out_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== hdl/ovl_ctrl.sv =====
// ---------------------------------------------------------------------------
// ovl_ctrl: command sequencer for the ordered value list.
// Accepts one item at a time, waits for the match vector, then issues either
// a single result or a read-out run, and owns the result valid flag.
// ---------------------------------------------------------------------------
module ovl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ovl_pkg::stat_type stat,
   output ovl_pkg::cmd_type  cmd
);
   import ovl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The result register can take a new result when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_ready       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.func == FUNC_READ && !stat.empty) begin
               state_in = S_READ;
            end else if (slot_free) begin
               cmd.emit_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_READ: begin
            if (slot_free) begin
               cmd.emit_read = 1'b1;
               if (stat.last_read) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (cmd.emit_single || cmd.emit_read) ? 1'b1
                   : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/ovl_checker.sv =====
// ---------------------------------------------------------------------------
// ovl_checker: port-level checks for the ordered value list.
// Watches the handshakes and result fields of the top level over time.
// ---------------------------------------------------------------------------
module ovl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ovl_pkg::STAT_W-1:0]       rsp_status,
   input logic [ovl_pkg::POS_W-1:0]        rsp_position,
   input logic signed [ovl_pkg::VAL_W-1:0] rsp_value_out,
   input logic                             rsp_last_of_run
);
   import ovl_pkg::*;

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_position) && $stable(rsp_value_out) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item accepted right after an accept");

   // No item is accepted while a read-out run is still open.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("item accepted during a read-out run");

   // Error results are single, with no position and no value.
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_last_of_run && rsp_position == '0 && rsp_value_out == '0)
      else $error("error result with payload");

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_position    (rsp_position),
   .rsp_value_out   (rsp_value_out),
   .rsp_last_of_run (rsp_last_of_run)
);
